// ===== rtl/mcs_pkg.sv =====
package mcs_pkg;

	typedef enum logic [2:0] {
		OP_LOOKUP      = 3'd0,
		OP_INSERT      = 3'd1,
		OP_EVICT       = 3'd2,
		OP_SET_DIRTY   = 3'd3,
		OP_CLEAR_DIRTY = 3'd4,
		OP_CLEAR_ALL   = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		RS_OK       = 3'd0,
		RS_MISS     = 3'd1,
		RS_PRESENT  = 3'd2,
		RS_FULL     = 3'd3,
		RS_NOT_FULL = 3'd4,
		RS_CLEARED  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_CMP  = 2'd1,
		S_UPD  = 2'd2
	} state_t;

	localparam int unsigned IN_TAG_W = 20;
	localparam int unsigned CFG_W    = 4;
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	typedef struct packed {
		logic [2:0]          op;
		logic [IN_TAG_W-1:0] tag;
	} req_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [IN_TAG_W-1:0] evicted_tag;
		logic                evicted_dirty;
		logic                evicted_valid;
		logic [3:0]          occupancy;
		logic [31:0]         eviction_count;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic compare;
		logic update;
	} cmd_t;

endpackage

// ===== rtl/mcs_ctrl.sv =====
module mcs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output mcs_pkg::cmd_t cmd
);

	mcs_pkg::state_t state_q;
	mcs_pkg::state_t state_d;
	logic            done_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mcs_pkg::S_IDLE: begin
				if (start) begin
					state_d = mcs_pkg::S_CMP;
				end
			end
			mcs_pkg::S_CMP: state_d = mcs_pkg::S_UPD;
			mcs_pkg::S_UPD: state_d = mcs_pkg::S_IDLE;
			default:        state_d = mcs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			mcs_pkg::S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			mcs_pkg::S_CMP:  cmd.compare = 1'b1;
			mcs_pkg::S_UPD:  cmd.update  = 1'b1;
			default:         busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcs_pkg::S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.update;
		end
	end

	assign done = done_q;

endmodule

// ===== rtl/mcs_dpath.sv =====
module mcs_dpath #(
	parameter int WAYS     = 8,
	parameter int TAG_BITS = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mcs_pkg::cmd_t                cmd,
	input  mcs_pkg::req_t                req,
	input  logic                         cfg_we,
	input  logic [mcs_pkg::CFG_W-1:0]    cfg_wdata,
	output mcs_pkg::rsp_t                rsp
);

	localparam int CW = $clog2(WAYS + 1);

	logic [mcs_pkg::CFG_W-1:0] ways_q;
	logic [2:0]                op_q;
	logic [TAG_BITS-1:0]       key_q;
	logic [TAG_BITS-1:0]       tag_q [WAYS];
	logic [TAG_BITS-1:0]       tag_d [WAYS];
	logic [WAYS-1:0]           dirty_q;
	logic [WAYS-1:0]           dirty_d;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             count_d;
	logic [31:0]               evc_q;
	logic [31:0]               evc_d;
	logic [WAYS-1:0]           hit_d;
	logic [WAYS-1:0]           hit_s1;
	logic [WAYS-1:0]           upto;
	logic                      hit_dirty_s1;
	logic [CW-1:0]             limit;
	logic                      full;
	mcs_pkg::rsp_t             rsp_d;
	mcs_pkg::rsp_t             rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_q <= mcs_pkg::CFG_RESET;
		end else if (cfg_we) begin
			ways_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (ways_q == '0) begin
			limit = CW'(1);
		end else if (32'(ways_q) > 32'(WAYS)) begin
			limit = CW'(WAYS);
		end else begin
			limit = CW'(ways_q);
		end
	end

	assign full = (count_q >= limit);

	// parallel tag match over the occupied part of the stack
	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			hit_d[i] = (count_q > CW'(i)) && (tag_q[i] == key_q);
		end
	end

	// entries at or above the hit position shift down on a lookup hit
	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			upto[i] = |(hit_s1 >> i);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req.op;
			key_q <= TAG_BITS'(req.tag);
		end
		if (cmd.compare) begin
			hit_s1       <= hit_d;
			hit_dirty_s1 <= |(hit_d & dirty_q);
		end
	end

	always_comb begin
		tag_d   = tag_q;
		dirty_d = dirty_q;
		count_d = count_q;
		evc_d   = evc_q;
		rsp_d   = '0;
		rsp_d.status = mcs_pkg::RS_MISS;
		case (op_q)
			mcs_pkg::OP_LOOKUP: begin
				if (|hit_s1) begin
					for (int i = 1; i < WAYS; i++) begin
						if (upto[i]) begin
							tag_d[i]   = tag_q[i-1];
							dirty_d[i] = dirty_q[i-1];
						end
					end
					tag_d[0]     = key_q;
					dirty_d[0]   = hit_dirty_s1;
					rsp_d.status = mcs_pkg::RS_OK;
				end
			end
			mcs_pkg::OP_INSERT: begin
				if (|hit_s1) begin
					rsp_d.status = mcs_pkg::RS_PRESENT;
				end else if (full || count_q >= CW'(WAYS)) begin
					rsp_d.status = mcs_pkg::RS_FULL;
				end else begin
					for (int i = 1; i < WAYS; i++) begin
						tag_d[i]   = tag_q[i-1];
						dirty_d[i] = dirty_q[i-1];
					end
					tag_d[0]     = key_q;
					dirty_d[0]   = 1'b0;
					count_d      = count_q + 1'b1;
					rsp_d.status = mcs_pkg::RS_OK;
				end
			end
			mcs_pkg::OP_EVICT: begin
				if (full && count_q != '0) begin
					rsp_d.evicted_tag   = mcs_pkg::IN_TAG_W'(tag_q[0]);
					rsp_d.evicted_dirty = dirty_q[0];
					rsp_d.evicted_valid = 1'b1;
					for (int i = 0; i < WAYS - 1; i++) begin
						tag_d[i]   = tag_q[i+1];
						dirty_d[i] = dirty_q[i+1];
					end
					count_d = count_q - 1'b1;
					if (~&evc_q) begin
						evc_d = evc_q + 32'd1;
					end
					rsp_d.status = mcs_pkg::RS_OK;
				end else begin
					rsp_d.status = mcs_pkg::RS_NOT_FULL;
				end
			end
			mcs_pkg::OP_SET_DIRTY, mcs_pkg::OP_CLEAR_DIRTY: begin
				if (|hit_s1) begin
					for (int i = 0; i < WAYS; i++) begin
						if (hit_s1[i]) begin
							dirty_d[i] = (op_q == mcs_pkg::OP_SET_DIRTY);
						end
					end
					rsp_d.status = mcs_pkg::RS_OK;
				end
			end
			mcs_pkg::OP_CLEAR_ALL: begin
				// stack contents are dead once the count is zero
				count_d      = '0;
				evc_d        = '0;
				rsp_d.status = mcs_pkg::RS_CLEARED;
			end
			default: rsp_d.status = mcs_pkg::RS_MISS;
		endcase
		rsp_d.occupancy      = 4'(count_d);
		rsp_d.eviction_count = evc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			evc_q   <= '0;
		end else if (cmd.update) begin
			count_q <= count_d;
			evc_q   <= evc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			tag_q   <= tag_d;
			dirty_q <= dirty_d;
			rsp_q   <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== rtl/mru_cache_set_core.sv =====
// One fully associative cache set with most-recently-used replacement. Drive
// an op word on req with start high; it is taken on the edge where busy is
// low. Every op passes through three steps (latch, parallel tag compare, stack
// update) and its one result word shows on rsp for exactly one cycle with done
// high, the cycle after the update; a new op may be started in that same cycle,
// so ops are paced by the controller's three states.
// The receiver cannot stall, so capture rsp whenever done is high. Write the
// ways limit through cfg_we/cfg_wdata only while no op is in flight.
module mru_cache_set_core #(
	parameter int WAYS     = 8,
	parameter int TAG_BITS = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  mcs_pkg::req_t             req,
	output logic                      done,
	output mcs_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [mcs_pkg::CFG_W-1:0] cfg_wdata
);

	mcs_pkg::cmd_t cmd;

	mcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	mcs_dpath #(
		.WAYS     (WAYS),
		.TAG_BITS (TAG_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp       (rsp)
	);

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted word did not enter the controller");

	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	a_evict_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.evicted_valid) |-> (rsp.status == mcs_pkg::RS_OK))
		else $error("evicted line without ok status");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(rsp.occupancy) <= 32'(WAYS)))
		else $error("occupancy above way count");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == mcs_pkg::RS_CLEARED)
		|-> (rsp.occupancy == '0 && rsp.eviction_count == '0))
		else $error("clear left state behind");
`endif

endmodule

// ===== dv/mru_cache_set_core_test.sv =====
module mru_cache_set_core_test;
	import mcs_pkg::*;

	localparam int SET_WAYS   = 8;
	localparam int PHASE_OPS  = 220;
	localparam int POOL_SIZE  = 10;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	req_t                 req = '0;
	logic                 done;
	rsp_t                 rsp;
	logic                 cfg_we = 1'b0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	// mirror of the set
	logic [IN_TAG_W-1:0]  line_tag [SET_WAYS];
	logic                 line_dirty [SET_WAYS];
	int                   line_total;
	logic [31:0]          evict_tally;
	logic [CFG_W-1:0]     ways_limit_reg;

	req_t                 op_backlog [$];
	rsp_t                 rsp_due [$];
	int                   idle_pct = 0;
	int                   faults = 0;
	int                   words_checked = 0;
	int                   lines_evicted = 0;
	int                   lookup_hits = 0;
	int                   ways_settings = 0;
	rsp_t                 want;

	mru_cache_set_core #(
		.WAYS(SET_WAYS),
		.TAG_BITS(IN_TAG_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Timeout: %0d ops still queued, %0d results outstanding",
			op_backlog.size(), rsp_due.size());
		$display("Simulation FAILED");
		$finish;
	end

	task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] exp_val);
		faults++;
		$display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, field, got,
			exp_val);
	endtask

	// Predict one op and advance the mirror.
	function automatic rsp_t mru_set_apply(req_t r);
		rsp_t                o;
		int                  limit;
		int                  pos;
		bit                  full;
		logic [IN_TAG_W-1:0] t;
		logic                d;
		limit = (ways_limit_reg == 0) ? 1 :
			((ways_limit_reg > SET_WAYS) ? SET_WAYS : int'(ways_limit_reg));
		full = line_total >= limit;
		pos = -1;
		for (int i = 0; i < line_total; i++) begin
			if (pos < 0 && line_tag[i] == r.tag)
				pos = i;
		end
		o = '0;
		o.status = RS_MISS;
		case (r.op)
			OP_LOOKUP: begin
				if (pos >= 0) begin
					t = line_tag[pos];
					d = line_dirty[pos];
					for (int i = pos; i > 0; i--) begin
						line_tag[i] = line_tag[i-1];
						line_dirty[i] = line_dirty[i-1];
					end
					line_tag[0] = t;
					line_dirty[0] = d;
					o.status = RS_OK;
					lookup_hits++;
				end
			end
			OP_INSERT: begin
				if (pos >= 0) begin
					o.status = RS_PRESENT;
				end else if (full || line_total >= SET_WAYS) begin
					o.status = RS_FULL;
				end else begin
					for (int i = line_total; i > 0; i--) begin
						line_tag[i] = line_tag[i-1];
						line_dirty[i] = line_dirty[i-1];
					end
					line_tag[0] = r.tag;
					line_dirty[0] = 1'b0;
					line_total++;
					o.status = RS_OK;
				end
			end
			OP_EVICT: begin
				if (full && line_total > 0) begin
					o.evicted_tag = line_tag[0];
					o.evicted_dirty = line_dirty[0];
					o.evicted_valid = 1'b1;
					for (int i = 1; i < line_total; i++) begin
						line_tag[i-1] = line_tag[i];
						line_dirty[i-1] = line_dirty[i];
					end
					line_total--;
					if (evict_tally != 32'hFFFF_FFFF)
						evict_tally++;
					o.status = RS_OK;
				end else begin
					o.status = RS_NOT_FULL;
				end
			end
			OP_SET_DIRTY, OP_CLEAR_DIRTY: begin
				if (pos >= 0) begin
					line_dirty[pos] = (r.op == OP_SET_DIRTY);
					o.status = RS_OK;
				end
			end
			OP_CLEAR_ALL: begin
				line_total = 0;
				evict_tally = '0;
				o.status = RS_CLEARED;
			end
			default: o.status = RS_MISS;
		endcase
		o.occupancy = line_total[3:0];
		o.eviction_count = evict_tally;
		return o;
	endfunction

	// Driver: hold a word on req until it is taken, then predict it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else begin
			if (start && !busy) begin
				rsp_due.push_back(mru_set_apply(req));
				op_backlog.delete(0);
			end
			if (!(start && busy)) begin
				if (op_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
					start <= 1'b1;
					req <= op_backlog[0];
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every done word must match the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (rsp_due.size() == 0) begin
				flag_mismatch("unexpected result word", 32'(rsp.status), 32'hFFFF_FFFF);
			end else begin
				want = rsp_due[0];
				rsp_due.delete(0);
				words_checked++;
				if (rsp.status !== want.status)
					flag_mismatch("status", 32'(rsp.status), 32'(want.status));
				if (rsp.evicted_tag !== want.evicted_tag)
					flag_mismatch("evicted_tag", 32'(rsp.evicted_tag),
						32'(want.evicted_tag));
				if (rsp.evicted_dirty !== want.evicted_dirty)
					flag_mismatch("evicted_dirty", 32'(rsp.evicted_dirty),
						32'(want.evicted_dirty));
				if (rsp.evicted_valid !== want.evicted_valid)
					flag_mismatch("evicted_valid", 32'(rsp.evicted_valid),
						32'(want.evicted_valid));
				if (rsp.occupancy !== want.occupancy)
					flag_mismatch("occupancy", 32'(rsp.occupancy), 32'(want.occupancy));
				if (rsp.eviction_count !== want.eviction_count)
					flag_mismatch("eviction_count", rsp.eviction_count,
						want.eviction_count);
				if (want.evicted_valid)
					lines_evicted++;
			end
		end
	end

	task automatic queue_op(logic [2:0] op, logic [IN_TAG_W-1:0] tag);
		req_t r;
		r.op = op;
		r.tag = tag;
		op_backlog.push_back(r);
	endtask

	task automatic write_ways(logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		ways_limit_reg = v;
		ways_settings++;
	endtask

	// Wait until every word is taken and every result has come back.
	task automatic drain();
		while (op_backlog.size() != 0 || rsp_due.size() != 0 || start)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int                  ways_plan [8] = '{3, 0, 15, 1, 8, 5, 9, 2};
		int                  idle_plan [4] = '{0, 47, 0, 29};
		logic [IN_TAG_W-1:0] tag_pool [POOL_SIZE];
		int                  roll;
		logic [2:0]          op;
		logic [IN_TAG_W-1:0] tag;

		line_total = 0;
		evict_tally = '0;
		ways_limit_reg = CFG_RESET;
		for (int i = 0; i < SET_WAYS; i++) begin
			line_tag[i] = '0;
			line_dirty[i] = 1'b0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		write_ways(4'd8);
		@(negedge clk);
		queue_op(OP_LOOKUP, 20'h00000);       // miss on empty set
		queue_op(OP_EVICT, 20'h00000);        // no evict when not full
		queue_op(OP_INSERT, 20'h00000);
		queue_op(OP_INSERT, 20'hFFFFF);
		queue_op(OP_INSERT, 20'h00000);       // already present
		queue_op(OP_SET_DIRTY, 20'hFFFFF);
		queue_op(OP_CLEAR_DIRTY, 20'h12345);  // absent tag
		queue_op(OP_SET_DIRTY, 20'h00000);
		queue_op(OP_CLEAR_DIRTY, 20'h00000);
		queue_op(OP_LOOKUP, 20'h00000);       // hit, back to the top
		queue_op(3'd6, 20'hABCDE);
		queue_op(3'd7, 20'h54321);
		queue_op(OP_INSERT, 20'hA5A5A);
		queue_op(OP_INSERT, 20'h5A5A5);
		queue_op(OP_INSERT, 20'h00001);
		queue_op(OP_SET_DIRTY, 20'h00001);
		queue_op(OP_INSERT, 20'h80000);
		queue_op(OP_INSERT, 20'h7FFFF);
		queue_op(OP_INSERT, 20'h00002);
		queue_op(OP_INSERT, 20'h00003);       // set full
		queue_op(OP_INSERT, 20'hFFFFF);       // present wins over full
		queue_op(OP_EVICT, 20'h00000);
		queue_op(OP_EVICT, 20'h00000);        // refused: one below the limit after the first evict
		queue_op(OP_CLEAR_ALL, 20'h00000);
		queue_op(OP_LOOKUP, 20'hFFFFF);
		drain();

		// Keep lines across phases so a lowered limit can land below occupancy.
		for (int ph = 0; ph < 8; ph++) begin
			write_ways(ways_plan[ph][CFG_W-1:0]);
			idle_pct = idle_plan[ph % 4];
			tag_pool[0] = 20'h00000;
			tag_pool[1] = 20'hFFFFF;
			for (int i = 2; i < POOL_SIZE; i++)
				tag_pool[i] = IN_TAG_W'($urandom);
			@(negedge clk);
			for (int n = 0; n < PHASE_OPS; n++) begin
				roll = $urandom_range(99);
				if (roll < 24)
					op = OP_LOOKUP;
				else if (roll < 50)
					op = OP_INSERT;
				else if (roll < 64)
					op = OP_EVICT;
				else if (roll < 77)
					op = OP_SET_DIRTY;
				else if (roll < 90)
					op = OP_CLEAR_DIRTY;
				else if (roll < 93)
					op = OP_CLEAR_ALL;
				else
					op = 3'($urandom_range(7, 6));
				if ($urandom_range(99) < 80)
					tag = tag_pool[$urandom_range(POOL_SIZE - 1)];
				else
					tag = IN_TAG_W'($urandom);
				queue_op(op, tag);
			end
			drain();
		end

		repeat (10) @(posedge clk);
		$display("Covered %0d ops over %0d ways settings, idle rates 0/29/47 percent",
			words_checked, ways_settings);
		$display("Lookup hits: %0d, lines evicted: %0d, mismatches: %0d",
			lookup_hits, lines_evicted, faults);
		if (faults == 0 && rsp_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
